FILE: sv/tcw_pkg.sv
// Package for the text console cell writer: geometry constants, codes,
// item structs and the sequencer state type. No dependencies.

package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int TAB_STOP   = 8;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	localparam int MEM_AW = $clog2(CELL_COUNT);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int TAB_W  = $clog2(TAB_STOP);

	localparam int LAST_ROW_BASE = CELL_COUNT - COLUMNS;
	localparam int COL_END_PH    = (COLUMNS - 1) % TAB_STOP;

	localparam logic [15:0] RESET_CELL = 16'h0700;

	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_TAB       = 8'd9;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_SPACE     = 8'd32;

	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	typedef logic [MEM_AW-1:0] addr_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  char_code;
		logic [3:0]  fg_colour;
		logic [3:0]  bg_colour;
		logic [10:0] read_address;
	} cmd_t;

	typedef struct packed {
		logic [10:0] cursor_pos;
		logic [15:0] cell_data;
	} result_t;

	typedef enum logic [6:0] {
		S_INIT   = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_PUT    = 7'b0000100,
		S_SCROLL = 7'b0001000,
		S_FILL   = 7'b0010000,
		S_RDWAIT = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

endpackage

FILE: sv/tcw_cell_ram.sv
// Cell store: one write port, one read port with registered read data.
// Depends on tcw_pkg for the depth and address type.

module tcw_cell_ram (
	input  logic           clk,
	input  logic           we,
	input  tcw_pkg::addr_t waddr,
	input  logic [15:0]    wdata,
	input  logic           re,
	input  tcw_pkg::addr_t raddr,
	output logic [15:0]    rdata
);

	logic [15:0] mem [tcw_pkg::CELL_COUNT];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/text_console_cell_writer.sv
// Top level of the text console cell writer: command sequencer, cursor
// and the cell store walk. Depends on tcw_pkg and tcw_cell_ram.
//
//   channel  signals                 handshake
//   item     start, cmd (cmd_t)      taken at an edge with start & !busy
//   result   done, result (result_t) one-cycle strobe, no back-pressure
//
// Return, backspace, newline above the bottom row, unused mode, read out of range:
// from accept straight to S_DONE, which raises done. Printable put passes S_PUT and
// a read in range passes S_RDWAIT first. Tab writes its spaces in S_PUT (up to TAB_STOP
// spaces). Newline or wrap on the bottom row scrolls through S_SCROLL, copying over the
// single write port of the cell store (one copied cell per cycle, then the row fill).
// Clear fills every cell in S_FILL. After reset a pass in S_INIT loads all
// cells with 0x0700 while busy stays high. The receiver cannot stall done.

module text_console_cell_writer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  tcw_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done,
	output tcw_pkg::result_t result
);

	tcw_pkg::state_t           state_q;
	tcw_pkg::addr_t            idx_q;
	tcw_pkg::addr_t            pos_q;
	logic [tcw_pkg::COL_W-1:0] col_q;
	logic [tcw_pkg::ROW_W-1:0] row_q;
	logic [tcw_pkg::TAB_W-1:0] ph_q;
	logic [15:0]               fill_q;
	logic [7:0]                ch_q;
	logic                      tab_q;
	logic [15:0]               data_q;
	logic                      copy_vld_s1;
	tcw_pkg::addr_t            copy_addr_s1;
	logic                      done_q;
	tcw_pkg::result_t          result_q;

	logic           mem_we;
	tcw_pkg::addr_t mem_waddr;
	logic [15:0]    mem_wdata;
	logic           mem_re;
	tcw_pkg::addr_t mem_raddr;
	logic [15:0]    mem_rdata;

	logic                      accept;
	logic                      read_in_range;
	logic                      col_end;
	logic                      row_last;
	logic [tcw_pkg::TAB_W-1:0] ph_inc;
	logic [15:0]               colour_in;

	assign busy          = (state_q != tcw_pkg::S_IDLE);
	assign accept        = start && !busy;
	assign read_in_range = (32'(cmd.read_address) < tcw_pkg::CELL_COUNT);
	assign col_end       = (col_q == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
	assign row_last      = (row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
	assign ph_inc        = (ph_q == tcw_pkg::TAB_W'(tcw_pkg::TAB_STOP - 1)) ? '0 : ph_q + 1'b1;
	assign colour_in     = {cmd.bg_colour, cmd.fg_colour, 8'h00};

	// cell store port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = fill_q;
		mem_re    = 1'b0;
		mem_raddr = tcw_pkg::addr_t'(32'(idx_q) + tcw_pkg::COLUMNS);
		case (state_q)
			tcw_pkg::S_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = tcw_pkg::RESET_CELL;
			end
			tcw_pkg::S_FILL: begin
				mem_we = 1'b1;
			end
			tcw_pkg::S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = fill_q | {8'h00, ch_q};
			end
			tcw_pkg::S_SCROLL: begin
				// each cell is read here and written to the row above in the next cycle
				mem_we    = copy_vld_s1;
				mem_waddr = copy_addr_s1;
				mem_wdata = mem_rdata;
				mem_re    = (idx_q != tcw_pkg::addr_t'(tcw_pkg::LAST_ROW_BASE));
			end
			tcw_pkg::S_IDLE: begin
				mem_re    = accept && (cmd.mode == tcw_pkg::MODE_READ) && read_in_range;
				mem_raddr = tcw_pkg::addr_t'(cmd.read_address);
			end
			default: begin
			end
		endcase
	end

	tcw_cell_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tcw_pkg::S_INIT;
			idx_q        <= '0;
			pos_q        <= '0;
			col_q        <= '0;
			row_q        <= '0;
			ph_q         <= '0;
			fill_q       <= '0;
			ch_q         <= '0;
			tab_q        <= 1'b0;
			data_q       <= '0;
			copy_vld_s1  <= 1'b0;
			copy_addr_s1 <= '0;
			done_q       <= 1'b0;
			result_q     <= '0;
		end else begin
			done_q       <= 1'b0;
			copy_vld_s1  <= 1'b0;
			copy_addr_s1 <= idx_q;
			case (state_q)
				tcw_pkg::S_INIT: begin
					if (idx_q == tcw_pkg::addr_t'(tcw_pkg::CELL_COUNT - 1)) begin
						idx_q   <= '0;
						state_q <= tcw_pkg::S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				tcw_pkg::S_IDLE: begin
					if (accept) begin
						fill_q  <= colour_in;
						data_q  <= '0;
						ch_q    <= cmd.char_code;
						tab_q   <= 1'b0;
						state_q <= tcw_pkg::S_DONE;
						case (cmd.mode)
							tcw_pkg::MODE_PUT: begin
								case (cmd.char_code)
									tcw_pkg::CH_NEWLINE: begin
										col_q <= '0;
										ph_q  <= '0;
										if (row_last) begin
											pos_q   <= tcw_pkg::addr_t'(tcw_pkg::LAST_ROW_BASE);
											idx_q   <= '0;
											state_q <= tcw_pkg::S_SCROLL;
										end else begin
											row_q <= row_q + 1'b1;
											pos_q <= tcw_pkg::addr_t'(32'(pos_q) - 32'(col_q)
												+ tcw_pkg::COLUMNS);
										end
									end
									tcw_pkg::CH_RETURN: begin
										col_q <= '0;
										ph_q  <= '0;
										pos_q <= pos_q - tcw_pkg::addr_t'(col_q);
									end
									tcw_pkg::CH_BACKSPACE: begin
										if (col_q != '0) begin
											col_q <= col_q - 1'b1;
											pos_q <= pos_q - 1'b1;
											ph_q  <= (ph_q == '0)
												? tcw_pkg::TAB_W'(tcw_pkg::TAB_STOP - 1)
												: ph_q - 1'b1;
										end else if (row_q != '0) begin
											col_q <= tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
											row_q <= row_q - 1'b1;
											pos_q <= pos_q - 1'b1;
											ph_q  <= tcw_pkg::TAB_W'(tcw_pkg::COL_END_PH);
										end
									end
									tcw_pkg::CH_TAB: begin
										ch_q    <= tcw_pkg::CH_SPACE;
										tab_q   <= 1'b1;
										state_q <= tcw_pkg::S_PUT;
									end
									default: begin
										state_q <= tcw_pkg::S_PUT;
									end
								endcase
							end
							tcw_pkg::MODE_CLEAR: begin
								idx_q   <= '0;
								col_q   <= '0;
								row_q   <= '0;
								pos_q   <= '0;
								ph_q    <= '0;
								state_q <= tcw_pkg::S_FILL;
							end
							tcw_pkg::MODE_READ: begin
								if (read_in_range) begin
									state_q <= tcw_pkg::S_RDWAIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				tcw_pkg::S_PUT: begin
					if (col_end) begin
						// wrap ends a tab as well
						col_q   <= '0;
						ph_q    <= '0;
						state_q <= tcw_pkg::S_DONE;
						if (row_last) begin
							pos_q   <= tcw_pkg::addr_t'(tcw_pkg::LAST_ROW_BASE);
							idx_q   <= '0;
							state_q <= tcw_pkg::S_SCROLL;
						end else begin
							row_q <= row_q + 1'b1;
							pos_q <= pos_q + 1'b1;
						end
					end else begin
						col_q <= col_q + 1'b1;
						pos_q <= pos_q + 1'b1;
						ph_q  <= ph_inc;
						if (!(tab_q && ph_inc != '0)) begin
							state_q <= tcw_pkg::S_DONE;
						end
					end
				end
				tcw_pkg::S_SCROLL: begin
					// last pass issues no read and only retires the pending copy
					if (idx_q == tcw_pkg::addr_t'(tcw_pkg::LAST_ROW_BASE)) begin
						state_q <= tcw_pkg::S_FILL;
					end else begin
						copy_vld_s1 <= 1'b1;
						idx_q       <= idx_q + 1'b1;
					end
				end
				tcw_pkg::S_FILL: begin
					if (idx_q == tcw_pkg::addr_t'(tcw_pkg::CELL_COUNT - 1)) begin
						state_q <= tcw_pkg::S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				tcw_pkg::S_RDWAIT: begin
					data_q  <= mem_rdata;
					state_q <= tcw_pkg::S_DONE;
				end
				tcw_pkg::S_DONE: begin
					done_q              <= 1'b1;
					result_q.cursor_pos <= 11'(pos_q);
					result_q.cell_data  <= data_q;
					state_q             <= tcw_pkg::S_IDLE;
				end
				default: begin
					state_q <= tcw_pkg::S_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: verif/text_console_cell_writer_tb.sv
// Self-checking testbench for text_console_cell_writer: directed and random console items
// go in, and every result is checked against a cycle-free model of the cell store and cursor.
// Depends on tcw_pkg and the text_console_cell_writer RTL.
`timescale 1ns / 100ps

module text_console_cell_writer_tb;

	localparam int RANDOM_ITEMS   = 1730;
	localparam int WATCHDOG_LIMIT = 10 * tcw_pkg::CELL_COUNT;
	localparam int TAIL_CYCLES    = 50;
	localparam int MAX_REPORTS    = 100;

	// Model of the console: cell store, cursor and the queue of results still owed.
	class console_scoreboard;
		logic [15:0]      cells [tcw_pkg::CELL_COUNT];
		int               cur_col;
		int               cur_row;
		tcw_pkg::result_t expected_q[$];
		int               errors;
		int               reported;
		int               n_put, n_clear, n_read, n_unused, n_scroll, n_tab_space;

		function new();
			foreach (cells[i])
				cells[i] = tcw_pkg::RESET_CELL;
			cur_col = 0;
			cur_row = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function int cursor_index();
			return cur_row * tcw_pkg::COLUMNS + cur_col;
		endfunction

		function void newline(logic [15:0] colour);
			cur_col = 0;
			if (cur_row >= tcw_pkg::ROWS - 1) begin
				cur_row = tcw_pkg::ROWS - 1;
				for (int i = 0; i < tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i++)
					cells[i] = cells[i + tcw_pkg::COLUMNS];
				for (int i = tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS;
				     i < tcw_pkg::CELL_COUNT; i++)
					cells[i] = colour;
				n_scroll++;
			end else begin
				cur_row++;
			end
		endfunction

		function void write_cell(logic [7:0] ch, logic [15:0] colour);
			cells[cursor_index()] = colour | {8'h00, ch};
			cur_col++;
			if (cur_col >= tcw_pkg::COLUMNS)
				newline(colour);
		endfunction

		function void put_char(logic [7:0] ch, logic [15:0] colour);
			case (ch)
				tcw_pkg::CH_NEWLINE: newline(colour);
				tcw_pkg::CH_RETURN: cur_col = 0;
				tcw_pkg::CH_BACKSPACE: begin
					if (cur_col > 0) begin
						cur_col--;
					end else if (cur_row > 0) begin
						cur_col = tcw_pkg::COLUMNS - 1;
						cur_row--;
					end
				end
				tcw_pkg::CH_TAB: begin
					write_cell(tcw_pkg::CH_SPACE, colour);
					n_tab_space++;
					// a wrap to column 0 also lands on a stop and ends the tab
					for (int n = 0; n < tcw_pkg::TAB_STOP && (cur_col % tcw_pkg::TAB_STOP) != 0;
					     n++) begin
						write_cell(tcw_pkg::CH_SPACE, colour);
						n_tab_space++;
					end
				end
				default: write_cell(ch, colour);
			endcase
		endfunction

		// Called once per accepted item.
		function void note_cmd(tcw_pkg::cmd_t c);
			logic [15:0]      colour;
			tcw_pkg::result_t want;
			colour = {c.bg_colour, c.fg_colour, 8'h00};
			want.cell_data = '0;
			case (c.mode)
				tcw_pkg::MODE_PUT: begin
					put_char(c.char_code, colour);
					n_put++;
				end
				tcw_pkg::MODE_CLEAR: begin
					foreach (cells[i])
						cells[i] = colour;
					cur_col = 0;
					cur_row = 0;
					n_clear++;
				end
				tcw_pkg::MODE_READ: begin
					if (c.read_address < tcw_pkg::CELL_COUNT)
						want.cell_data = cells[c.read_address];
					n_read++;
				end
				default: n_unused++;
			endcase
			want.cursor_pos = 11'(cursor_index());
			expected_q.push_back(want);
		endfunction

		function void mismatch(string field, logic [15:0] want, logic [15:0] got);
			errors++;
			if (reported < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			else if (reported == MAX_REPORTS)
				$display("%0t: further mismatches not shown", $time);
			reported++;
		endfunction

		function void check_result(tcw_pkg::result_t got);
			tcw_pkg::result_t want;
			if (expected_q.size() == 0) begin
				mismatch("unexpected result", '0, {5'd0, got.cursor_pos});
				return;
			end
			want = expected_q.pop_front();
			if (got.cursor_pos !== want.cursor_pos)
				mismatch("cursor_pos", {5'd0, want.cursor_pos}, {5'd0, got.cursor_pos});
			if (got.cell_data !== want.cell_data)
				mismatch("cell_data", want.cell_data, got.cell_data);
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	tcw_pkg::cmd_t    cmd;
	logic             busy;
	logic             done;
	tcw_pkg::result_t result;

	console_scoreboard sb;
	int n_sent;
	int idle_cycles = 0;

	text_console_cell_writer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("text_console_cell_writer_tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic tcw_pkg::cmd_t make_cmd(logic [1:0] mode, logic [7:0] ch,
						   logic [3:0] fg, logic [3:0] bg,
						   logic [10:0] addr);
		tcw_pkg::cmd_t c;
		c.mode = mode;
		c.char_code = ch;
		c.fg_colour = fg;
		c.bg_colour = bg;
		c.read_address = addr;
		return c;
	endfunction

	function automatic tcw_pkg::cmd_t random_cmd();
		tcw_pkg::cmd_t c;
		int            r;
		int            k;
		c.fg_colour = 4'($urandom_range(0, 15));
		c.bg_colour = 4'($urandom_range(0, 15));
		c.read_address = 11'($urandom_range(0, 2047));
		r = $urandom_range(0, 99);
		// clears and scrolls walk the whole store, so clears stay rare
		if (r < 1)
			c.mode = tcw_pkg::MODE_CLEAR;
		else if (r < 4)
			c.mode = 2'd3;
		else if (r < 16)
			c.mode = tcw_pkg::MODE_READ;
		else
			c.mode = tcw_pkg::MODE_PUT;
		r = $urandom_range(0, 99);
		if (r < 6)
			c.char_code = tcw_pkg::CH_NEWLINE;
		else if (r < 10)
			c.char_code = tcw_pkg::CH_RETURN;
		else if (r < 18)
			c.char_code = tcw_pkg::CH_BACKSPACE;
		else if (r < 26)
			c.char_code = tcw_pkg::CH_TAB;
		else
			c.char_code = 8'($urandom_range(0, 255));
		if (c.mode == tcw_pkg::MODE_READ) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				c.read_address = 11'($urandom_range(tcw_pkg::CELL_COUNT, 2047));
			end else if (r < 55) begin
				// look just behind the cursor, where fresh writes are
				k = $urandom_range(0, 2 * tcw_pkg::COLUMNS);
				c.read_address = 11'((sb.cursor_index() + tcw_pkg::CELL_COUNT - k)
					% tcw_pkg::CELL_COUNT);
			end else begin
				c.read_address = 11'($urandom_range(0, tcw_pkg::CELL_COUNT - 1));
			end
		end
		return c;
	endfunction

	task automatic send_cmd(input tcw_pkg::cmd_t c, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		sb.note_cmd(c);
		n_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() > 0);
	endtask

	initial begin
		tcw_pkg::cmd_t directed_q[$];
		int            gap;

		sb = new();
		n_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		directed_q = '{
			make_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd0),
			make_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd1999),
			make_cmd(tcw_pkg::MODE_READ, 8'hFF, 4'hF, 4'hF, 11'd2047),
			make_cmd(2'd3, 8'hFF, 4'hF, 4'hF, 11'd2047),
			make_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_BACKSPACE, 4'h1, 4'h2, 11'd0),
			make_cmd(tcw_pkg::MODE_PUT, 8'h00, 4'h0, 4'h0, 11'd0),
			make_cmd(tcw_pkg::MODE_PUT, 8'hFF, 4'hF, 4'hF, 11'd0),
			make_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_TAB, 4'h5, 4'hA, 11'd0),
			make_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd1),
			make_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd7),
			make_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_RETURN, 4'h0, 4'h0, 11'd0),
			make_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_NEWLINE, 4'h6, 4'h9, 11'd0),
			make_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_BACKSPACE, 4'h0, 4'h0, 11'd0),
			make_cmd(tcw_pkg::MODE_PUT, 8'h41, 4'hE, 4'h1, 11'd0),
			make_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_BACKSPACE, 4'h0, 4'h0, 11'd0),
			make_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_TAB, 4'h7, 4'h3, 11'd0),
			make_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd79),
			make_cmd(tcw_pkg::MODE_CLEAR, 8'h00, 4'h3, 4'hC, 11'd0),
			make_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd1234),
			make_cmd(tcw_pkg::MODE_PUT, tcw_pkg::CH_NEWLINE, 4'h2, 4'h4, 11'd0),
			make_cmd(tcw_pkg::MODE_PUT, 8'h5A, 4'hB, 4'h8, 11'd0),
			make_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd80)
		};
		foreach (directed_q[i])
			send_cmd(directed_q[i], $urandom_range(0, 4));
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			gap = $urandom_range(0, 4);
			if (i == RANDOM_ITEMS / 2)
				drain();
			send_cmd(random_cmd(), gap);
		end
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d items: %0d put, %0d clear, %0d read, %0d unused mode", n_sent,
			 sb.n_put, sb.n_clear, sb.n_read, sb.n_unused);
		$display("%0d scrolls, %0d tab spaces, %0d mismatches", sb.n_scroll,
			 sb.n_tab_space, sb.errors);
		if (sb.errors == 0)
			$display("text_console_cell_writer_tb: clean");
		else
			$display("text_console_cell_writer_tb: errors");
		$finish;
	end

endmodule
